// ===== hw/rtl/nlc_pkg.sv =====
// nlc_pkg: word types, character constants and recognizer state encodings
// for the numeric literal classifier; no dependencies

package nlc_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } in_word_t;

    typedef struct packed {
        logic dec_int;
        logic oct_int;
        logic hex_int;
        logic dec_float;
        logic hex_float;
        logic any_number;
    } out_word_t;

    typedef struct packed {
        logic is_dig;
        logic is_oct;
        logic is_hex;
        logic is_sgn;
        logic is_e;
        logic is_p;
        logic is_x;
        logic is_dot;
        logic is_zero;
    } char_class_t;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_UE    = 8'h45;
    localparam logic [7:0] CH_LP    = 8'h70;
    localparam logic [7:0] CH_UP    = 8'h50;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;

    localparam logic [2:0] CNT_MAX    = 3'd7;
    localparam logic [3:0] HF_MIN_LEN = 4'd5;

    typedef enum logic [2:0] {
        I_START = 3'd0,
        I_SIGN  = 3'd1,
        I_ZERO  = 3'd2,
        I_BODY  = 3'd3,
        I_X     = 3'd4,
        I_DEAD  = 3'd7
    } int_phase_t;

    typedef enum logic [3:0] {
        DF_START = 4'd0,
        DF_SIGN  = 4'd1,
        DF_LDOT  = 4'd2,
        DF_FRAC  = 4'd3,
        DF_INT   = 4'd4,
        DF_TDOT  = 4'd5,
        DF_EXPE  = 4'd6,
        DF_EXPS  = 4'd7,
        DF_EXPD  = 4'd8,
        DF_DEAD  = 4'd15
    } df_phase_t;

    typedef enum logic [3:0] {
        HF_START = 4'd0,
        HF_SIGN  = 4'd1,
        HF_ZERO  = 4'd2,
        HF_X     = 4'd3,
        HF_LDOT  = 4'd4,
        HF_MANT  = 4'd5,
        HF_FRAC  = 4'd6,
        HF_P     = 4'd7,
        HF_PSIGN = 4'd8,
        HF_PDIG  = 4'd9,
        HF_DEAD  = 4'd15
    } hf_phase_t;

endpackage

// ===== hw/rtl/numeric_literal_classifier.sv =====
// numeric_literal_classifier: input register, recognizers, result register
// depends on nlc_pkg, nlc_char_class and nlc_fsm
//
// Usage: a token is sent one character per word on the s_ channel
// (valid/ready), with last_char set on its final character. Each word is
// held in an input register, then run through five recognizers (decimal,
// octal and hex integer, decimal and hex float) in parallel. Only the word
// that carries last_char produces a result word on the m_ channel, with the
// five verdicts and their OR; the recognizers then return to their start
// state for the next token.
// Path: a last character is held in the input register; its verdict is
// then written to the result register. Throughput: one character per
// cycle while s_ready is high; each of the two registers holds one word.
// Stall: while a result waits on m_ready, characters that give no result
// still advance; a further last character waits in the input register and
// s_ready drops until the result register frees up.
// Reset: aresetn low for one edge empties both registers and returns all
// recognizers to their start state.

module numeric_literal_classifier import nlc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    logic        in_valid_reg;
    in_word_t    in_word_reg;
    logic        out_valid_reg;
    out_word_t   out_word_reg;
    logic        out_free;
    logic        step;
    char_class_t cls;
    out_word_t   verdict;

    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && (!in_word_reg.last_char || out_free);
    assign s_ready  = !in_valid_reg || step;
    assign m_valid  = out_valid_reg;
    assign m_word   = out_word_reg;

    nlc_char_class u_class (
        .char_code (in_word_reg.char_code),
        .cls       (cls)
    );

    nlc_fsm u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .last_char (in_word_reg.last_char),
        .cls       (cls),
        .verdict   (verdict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && in_word_reg.last_char) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && in_word_reg.last_char) begin
            out_word_reg <= verdict;
        end
    end

endmodule

// ===== hw/rtl/nlc_char_class.sv =====
// nlc_char_class: decodes one character into the classes the recognizers use
// depends on nlc_pkg

module nlc_char_class import nlc_pkg::*; (
    input  logic [7:0]  char_code,
    output char_class_t cls
);

    always_comb begin
        cls.is_dig  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        cls.is_oct  = (char_code >= CH_ZERO) && (char_code <= CH_SEVEN);
        cls.is_hex  = cls.is_dig
                      || ((char_code >= CH_LA) && (char_code <= CH_LF))
                      || ((char_code >= CH_UA) && (char_code <= CH_UF));
        cls.is_sgn  = (char_code == CH_PLUS) || (char_code == CH_MINUS);
        cls.is_e    = (char_code == CH_LE) || (char_code == CH_UE);
        cls.is_p    = (char_code == CH_LP) || (char_code == CH_UP);
        cls.is_x    = (char_code == CH_LX) || (char_code == CH_UX);
        cls.is_dot  = (char_code == CH_DOT);
        cls.is_zero = (char_code == CH_ZERO);
    end

endmodule

// ===== hw/rtl/nlc_fsm.sv =====
// nlc_fsm: the five literal recognizers, length count and sign flag
// depends on nlc_pkg; verdicts are taken from the updated state

module nlc_fsm import nlc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic        last_char,
    input  char_class_t cls,
    output out_word_t   verdict
);

    int_phase_t dec_int_reg, dec_int_next;
    int_phase_t oct_int_reg, oct_int_next;
    int_phase_t hex_int_reg, hex_int_next;
    df_phase_t  dec_float_reg, dec_float_next;
    hf_phase_t  hex_float_reg, hex_float_next;
    logic [2:0] chars_seen_reg, chars_seen_next;
    logic       signed_prefix_reg, signed_prefix_next;

    // decimal integer
    always_comb begin
        case (dec_int_reg)
            I_START: begin
                if (cls.is_sgn)      dec_int_next = I_SIGN;
                else if (cls.is_zero) dec_int_next = I_ZERO;
                else if (cls.is_dig) dec_int_next = I_BODY;
                else                 dec_int_next = I_DEAD;
            end
            I_SIGN: begin
                if (cls.is_zero)     dec_int_next = I_ZERO;
                else if (cls.is_dig) dec_int_next = I_BODY;
                else                 dec_int_next = I_DEAD;
            end
            I_BODY:  dec_int_next = cls.is_dig ? I_BODY : I_DEAD;
            default: dec_int_next = I_DEAD;
        endcase
    end

    // octal integer
    always_comb begin
        case (oct_int_reg)
            I_START: begin
                if (cls.is_sgn)       oct_int_next = I_SIGN;
                else if (cls.is_zero) oct_int_next = I_ZERO;
                else                  oct_int_next = I_DEAD;
            end
            I_SIGN:  oct_int_next = cls.is_zero ? I_ZERO : I_DEAD;
            I_ZERO,
            I_BODY:  oct_int_next = cls.is_oct ? I_BODY : I_DEAD;
            default: oct_int_next = I_DEAD;
        endcase
    end

    // hexadecimal integer
    always_comb begin
        case (hex_int_reg)
            I_START: begin
                if (cls.is_sgn)       hex_int_next = I_SIGN;
                else if (cls.is_zero) hex_int_next = I_ZERO;
                else                  hex_int_next = I_DEAD;
            end
            I_SIGN:  hex_int_next = cls.is_zero ? I_ZERO : I_DEAD;
            I_ZERO:  hex_int_next = cls.is_x ? I_X : I_DEAD;
            I_X,
            I_BODY:  hex_int_next = cls.is_hex ? I_BODY : I_DEAD;
            default: hex_int_next = I_DEAD;
        endcase
    end

    // decimal float
    always_comb begin
        case (dec_float_reg)
            DF_START: begin
                if (cls.is_sgn)      dec_float_next = DF_SIGN;
                else if (cls.is_dot) dec_float_next = DF_LDOT;
                else if (cls.is_dig) dec_float_next = DF_INT;
                else                 dec_float_next = DF_DEAD;
            end
            DF_SIGN: begin
                if (cls.is_dot)      dec_float_next = DF_LDOT;
                else if (cls.is_dig) dec_float_next = DF_INT;
                else                 dec_float_next = DF_DEAD;
            end
            DF_LDOT: dec_float_next = cls.is_dig ? DF_FRAC : DF_DEAD;
            DF_INT: begin
                if (cls.is_dig)      dec_float_next = DF_INT;
                else if (cls.is_dot) dec_float_next = DF_TDOT;
                else if (cls.is_e)   dec_float_next = DF_EXPE;
                else                 dec_float_next = DF_DEAD;
            end
            DF_TDOT,
            DF_FRAC: begin
                if (cls.is_dig)      dec_float_next = DF_FRAC;
                else if (cls.is_e)   dec_float_next = DF_EXPE;
                else                 dec_float_next = DF_DEAD;
            end
            DF_EXPE: begin
                if (cls.is_sgn)      dec_float_next = DF_EXPS;
                else if (cls.is_dig) dec_float_next = DF_EXPD;
                else                 dec_float_next = DF_DEAD;
            end
            DF_EXPS,
            DF_EXPD: dec_float_next = cls.is_dig ? DF_EXPD : DF_DEAD;
            default: dec_float_next = DF_DEAD;
        endcase
    end

    // hexadecimal float
    always_comb begin
        case (hex_float_reg)
            HF_START: begin
                if (cls.is_sgn)       hex_float_next = HF_SIGN;
                else if (cls.is_zero) hex_float_next = HF_ZERO;
                else                  hex_float_next = HF_DEAD;
            end
            HF_SIGN:  hex_float_next = cls.is_zero ? HF_ZERO : HF_DEAD;
            HF_ZERO:  hex_float_next = cls.is_x ? HF_X : HF_DEAD;
            HF_X: begin
                if (cls.is_dot)      hex_float_next = HF_LDOT;
                else if (cls.is_hex) hex_float_next = HF_MANT;
                else if (cls.is_p)   hex_float_next = HF_P;
                else                 hex_float_next = HF_DEAD;
            end
            HF_LDOT:  hex_float_next = cls.is_hex ? HF_FRAC : HF_DEAD;
            HF_MANT: begin
                if (cls.is_hex)      hex_float_next = HF_MANT;
                else if (cls.is_dot) hex_float_next = HF_FRAC;
                else if (cls.is_p)   hex_float_next = HF_P;
                else                 hex_float_next = HF_DEAD;
            end
            HF_FRAC: begin
                if (cls.is_hex)      hex_float_next = HF_FRAC;
                else if (cls.is_p)   hex_float_next = HF_P;
                else                 hex_float_next = HF_DEAD;
            end
            HF_P: begin
                if (cls.is_sgn)      hex_float_next = HF_PSIGN;
                else if (cls.is_hex) hex_float_next = HF_PDIG;
                else                 hex_float_next = HF_DEAD;
            end
            HF_PSIGN,
            HF_PDIG:  hex_float_next = cls.is_hex ? HF_PDIG : HF_DEAD;
            default:  hex_float_next = HF_DEAD;
        endcase
    end

    // length count and sign flag
    always_comb begin
        signed_prefix_next = (chars_seen_reg == 3'd0) ? cls.is_sgn : signed_prefix_reg;
        chars_seen_next    = (chars_seen_reg == CNT_MAX) ? CNT_MAX : chars_seen_reg + 3'd1;
    end

    // verdicts from the updated state
    always_comb begin
        verdict.dec_int   = (dec_int_next == I_ZERO) || (dec_int_next == I_BODY);
        verdict.oct_int   = (oct_int_next == I_BODY);
        verdict.hex_int   = (hex_int_next == I_BODY);
        verdict.dec_float = (dec_float_next == DF_FRAC) || (dec_float_next == DF_TDOT)
                            || (dec_float_next == DF_EXPD);
        verdict.hex_float = (hex_float_next == HF_PDIG)
                            && ({1'b0, chars_seen_next}
                                >= (HF_MIN_LEN + {3'd0, signed_prefix_next}));
        verdict.any_number = verdict.dec_int | verdict.oct_int | verdict.hex_int
                             | verdict.dec_float | verdict.hex_float;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_char)) begin
            dec_int_reg       <= I_START;
            oct_int_reg       <= I_START;
            hex_int_reg       <= I_START;
            dec_float_reg     <= DF_START;
            hex_float_reg     <= HF_START;
            chars_seen_reg    <= 3'd0;
            signed_prefix_reg <= 1'b0;
        end else if (step) begin
            dec_int_reg       <= dec_int_next;
            oct_int_reg       <= oct_int_next;
            hex_int_reg       <= hex_int_next;
            dec_float_reg     <= dec_float_next;
            hex_float_reg     <= hex_float_next;
            chars_seen_reg    <= chars_seen_next;
            signed_prefix_reg <= signed_prefix_next;
        end
    end

endmodule
